FILE: design/dq_pkg.sv
// Shared types, command and status codes, and ring index helpers for the deque.
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 4;
    localparam int STAT_W     = 2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [WORD_W-1:0]     word_t;
    typedef logic [AW-1:0]                idx_t;
    typedef logic [CW-1:0]                cnt_t;
    typedef logic [CMD_W-1:0]             cmd_t;
    typedef logic [POS_W-1:0]             pos_t;
    typedef logic [STAT_W-1:0]            stat_t;

    // Command codes
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_READ       = 3'd4;
    localparam cmd_t CMD_SORT       = 3'd5;
    localparam cmd_t CMD_REVERSE    = 3'd6;
    localparam cmd_t CMD_CLEAR      = 3'd7;

    // Status codes
    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_RANGE = 2'd2;
    localparam stat_t STAT_FULL  = 2'd3;

    // Access request from the sequencer to the ring store (logical indexes)
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_idx;
        data_t wr_data;
        idx_t  rd_idx;
    } ring_req_t;

    // Map a position counted from the front to a physical ring slot
    function automatic idx_t slot(idx_t fp, idx_t idx);
        logic [AW:0] sum;
        begin
            sum = {1'b0, fp} + {1'b0, idx};
            if (sum >= (AW + 1)'(DEPTH))
            begin
                sum = sum - (AW + 1)'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    // Bring an input word to the stored width (truncate or sign-extend)
    function automatic data_t to_data(word_t w);
        return data_t'(w);
    endfunction

    // Bring a stored value to the output word width (truncate or sign-extend)
    function automatic word_t to_word(data_t d);
        return word_t'(d);
    endfunction

endpackage

FILE: design/dq_ring.sv
// Ring store: one write port and one registered read port, both addressed from the front.
module dq_ring (
    input  logic              clk,
    input  dq_pkg::idx_t      front_ptr,
    input  dq_pkg::ring_req_t req,
    output dq_pkg::data_t     rd_data
);
    import dq_pkg::*;

    data_t store [DEPTH];
    data_t rd_data_reg;
    idx_t  wr_slot;
    idx_t  rd_slot;

    // Translate logical positions to physical slots
    assign wr_slot = slot(front_ptr, req.wr_idx);
    assign rd_slot = slot(front_ptr, req.rd_idx);

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store[wr_slot] <= req.wr_data;
        end
        rd_data_reg <= store[rd_slot];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/dq_cmp.sv
// Shared compare unit: decides whether a pair of entries is exchanged.
module dq_cmp (
    input  dq_pkg::data_t lo_val,
    input  dq_pkg::data_t hi_val,
    input  logic          force_swap,
    output logic          swap
);
    import dq_pkg::*;

    // Exchange when out of ascending order, or always when reversing
    assign swap = force_swap | (lo_val > hi_val);

endmodule

FILE: design/bounded_deque_with_sort_reverse.sv
// Top level: command sequencer, output word register, ring store and compare unit.
//
// Bounded deque of signed values in a 16-entry ring. A command is taken when start is high
// and busy is low; busy then stays high until the result word is ready. Exactly one result
// word follows each command, on the result ports for one cycle with done high, and it must
// be captured then since the block cannot be held off. Push, pop, read and clear run the steps
// execute, read front, read back and load result in that order, set by the single read port of
// the ring store. Sort is an exchange sort over the shared compare unit: with n stored values it
// runs n*(n-1)/2 compare steps (read low, read high, compare and write low, write high) between
// the execute and read front steps above. Reverse runs floor(n/2) exchange steps in the same way.
module bounded_deque_with_sort_reverse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dq_pkg::cmd_t        cmd,
    input  dq_pkg::word_t       value_in,
    input  dq_pkg::pos_t        position,
    output logic                busy,
    output logic                done,
    output dq_pkg::word_t       value_out,
    output dq_pkg::stat_t       status,
    output dq_pkg::cnt_t        fill_count,
    output logic                is_empty,
    output dq_pkg::word_t       front_value,
    output dq_pkg::word_t       back_value
);
    import dq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_SWB   = 4'd5;
    localparam logic [3:0] S_FRONT = 4'd6;
    localparam logic [3:0] S_BACK  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // Control state
    logic [3:0] state_reg, state_next;
    idx_t       fp_reg, fp_next;
    cnt_t       cnt_reg, cnt_next;
    idx_t       lo_reg, lo_next;
    idx_t       hi_reg, hi_next;
    idx_t       last_reg, last_next;
    logic       swap_reg, swap_next;
    logic       cap_reg, cap_next;
    logic       done_reg, done_next;

    // Payload state
    cmd_t       cmd_reg, cmd_next;
    data_t      val_reg, val_next;
    pos_t       pos_reg, pos_next;
    data_t      a_reg, a_next;
    data_t      res_reg, res_next;
    stat_t      stat_reg, stat_next;
    data_t      front_reg, front_next;
    word_t      value_out_reg, value_out_next;
    stat_t      status_reg, status_next;
    cnt_t       fill_reg, fill_next;
    logic       empty_reg, empty_next;
    word_t      front_out_reg, front_out_next;
    word_t      back_out_reg, back_out_next;

    ring_req_t  req;
    data_t      rd_data;
    logic       swap;
    idx_t       back_idx;

    dq_ring u_ring (
        .clk       (clk),
        .front_ptr (fp_reg),
        .req       (req),
        .rd_data   (rd_data)
    );

    dq_cmp u_cmp (
        .lo_val     (a_reg),
        .hi_val     (rd_data),
        .force_swap (cmd_reg == CMD_REVERSE),
        .swap       (swap)
    );

    assign back_idx = (cnt_reg == '0) ? '0 : idx_t'(cnt_reg - cnt_t'(1));

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        fp_next        = fp_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_next      = last_reg;
        swap_next      = swap_reg;
        cap_next       = cap_reg;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        a_next         = a_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        front_next     = front_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        empty_next     = empty_reg;
        front_out_next = front_out_reg;
        back_out_next  = back_out_reg;
        req.wr_en      = 1'b0;
        req.wr_idx     = lo_reg;
        req.wr_data    = rd_data;
        req.rd_idx     = lo_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take a new command word
                if (start)
                begin
                    cmd_next   = cmd;
                    val_next   = to_data(value_in);
                    pos_next   = position;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                stat_next  = STAT_OK;
                cap_next   = 1'b0;
                res_next   = '0;
                state_next = S_FRONT;
                case (cmd_reg)
                    CMD_PUSH_FRONT:
                    begin
                        if (cnt_reg == cnt_t'(DEPTH))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_idx  = idx_t'(DEPTH - 1);
                            req.wr_data = val_reg;
                            fp_next     = slot(fp_reg, idx_t'(DEPTH - 1));
                            cnt_next    = cnt_reg + cnt_t'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (cnt_reg == cnt_t'(DEPTH))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_idx  = idx_t'(cnt_reg);
                            req.wr_data = val_reg;
                            cnt_next    = cnt_reg + cnt_t'(1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (cnt_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else
                        begin
                            req.rd_idx = '0;
                            cap_next   = 1'b1;
                            fp_next    = slot(fp_reg, idx_t'(1));
                            cnt_next   = cnt_reg - cnt_t'(1);
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (cnt_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else
                        begin
                            req.rd_idx = back_idx;
                            cap_next   = 1'b1;
                            cnt_next   = cnt_reg - cnt_t'(1);
                        end
                    end
                    CMD_READ:
                    begin
                        if (cnt_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else if (32'(pos_reg) >= 32'(cnt_reg))
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else
                        begin
                            req.rd_idx = idx_t'(pos_reg);
                            cap_next   = 1'b1;
                        end
                    end
                    CMD_SORT:
                    begin
                        if (cnt_reg >= cnt_t'(2))
                        begin
                            lo_next    = '0;
                            hi_next    = idx_t'(1);
                            last_next  = back_idx;
                            state_next = S_RDA;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        if (cnt_reg >= cnt_t'(2))
                        begin
                            lo_next    = '0;
                            hi_next    = back_idx;
                            state_next = S_RDA;
                        end
                    end
                    default:
                    begin
                        // Clear: drop all entries
                        cnt_next = '0;
                        fp_next  = '0;
                    end
                endcase
            end
            S_RDA:
            begin
                req.rd_idx = lo_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                req.rd_idx = hi_reg;
                a_next     = rd_data;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Decide exchange and move the high value down
                req.wr_en   = swap;
                req.wr_idx  = lo_reg;
                req.wr_data = rd_data;
                swap_next   = swap;
                state_next  = S_SWB;
            end
            S_SWB:
            begin
                req.wr_en   = swap_reg;
                req.wr_idx  = hi_reg;
                req.wr_data = a_reg;
                // Advance to the next pair
                if (cmd_reg == CMD_REVERSE)
                begin
                    if (({1'b0, lo_reg} + (AW + 1)'(2)) < {1'b0, hi_reg})
                    begin
                        lo_next    = lo_reg + idx_t'(1);
                        hi_next    = hi_reg - idx_t'(1);
                        state_next = S_RDA;
                    end
                    else
                    begin
                        state_next = S_FRONT;
                    end
                end
                else if (hi_reg == last_reg)
                begin
                    if (last_reg == idx_t'(1))
                    begin
                        state_next = S_FRONT;
                    end
                    else
                    begin
                        last_next  = last_reg - idx_t'(1);
                        lo_next    = '0;
                        hi_next    = idx_t'(1);
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    lo_next    = lo_reg + idx_t'(1);
                    hi_next    = hi_reg + idx_t'(1);
                    state_next = S_RDA;
                end
            end
            S_FRONT:
            begin
                req.rd_idx = '0;
                if (cap_reg)
                begin
                    res_next = rd_data;
                end
                state_next = S_BACK;
            end
            S_BACK:
            begin
                req.rd_idx = back_idx;
                front_next = rd_data;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Load the result word
                value_out_next = to_word(res_reg);
                status_next    = stat_reg;
                fill_next      = cnt_reg;
                empty_next     = (cnt_reg == '0);
                front_out_next = (cnt_reg == '0) ? '0 : to_word(front_reg);
                back_out_next  = (cnt_reg == '0) ? '0 : to_word(rd_data);
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fp_reg    <= '0;
            cnt_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            last_reg  <= '0;
            swap_reg  <= 1'b0;
            cap_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fp_reg    <= fp_next;
            cnt_reg   <= cnt_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            last_reg  <= last_next;
            swap_reg  <= swap_next;
            cap_reg   <= cap_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        a_reg         <= a_next;
        res_reg       <= res_next;
        stat_reg      <= stat_next;
        front_reg     <= front_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        fill_reg      <= fill_next;
        empty_reg     <= empty_next;
        front_out_reg <= front_out_next;
        back_out_reg  <= back_out_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign value_out   = value_out_reg;
    assign status      = status_reg;
    assign fill_count  = fill_reg;
    assign is_empty    = empty_reg;
    assign front_value = front_out_reg;
    assign back_value  = back_out_reg;

endmodule

FILE: design/dq_checker.sv
// Port-level checks on the deque, attached to the top level by bind.
module dq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input dq_pkg::word_t value_out,
    input dq_pkg::stat_t status,
    input dq_pkg::cnt_t  fill_count,
    input logic          is_empty,
    input dq_pkg::word_t front_value,
    input dq_pkg::word_t back_value
);
    import dq_pkg::*;

    // An accepted command word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command accept");

    // The result word appears only once the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // Empty flag and count agree, count within capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (fill_count == '0)) && (fill_count <= cnt_t'(DEPTH)))
        else $error("empty flag or count inconsistent");

    // An empty deque reports zero front and back values
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_empty |-> (front_value == '0) && (back_value == '0))
        else $error("front or back value nonzero on empty deque");

    // An error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_OK) |-> (value_out == '0))
        else $error("nonzero value on error result");

endmodule

bind bounded_deque_with_sort_reverse dq_checker u_dq_checker (.*);

FILE: sim/bounded_deque_with_sort_reverse_tb.sv
// Self-checking testbench for the bounded deque with sort and reverse.
module bounded_deque_with_sort_reverse_tb;

    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // One expected result word
    typedef struct {
        word_t value;
        stat_t status;
        cnt_t  fill;
        logic  empty;
        word_t front;
        word_t back;
    } deque_report_t;

    // Command mix of the random traffic
    typedef enum int unsigned {FILL_UP, DRAIN_DOWN, MIXED} traffic_mode_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  start      = 1'b0;
    cmd_t  cmd        = CMD_PUSH_BACK;
    word_t value_in   = '0;
    pos_t  position   = '0;
    logic  busy;
    logic  done;
    word_t value_out;
    stat_t status;
    cnt_t  fill_count;
    logic  is_empty;
    word_t front_value;
    word_t back_value;

    // Mirror of the ring store
    data_t model_ring [DEPTH];
    int    model_head  = 0;
    int    model_count = 0;

    deque_report_t expected_reports [$];
    deque_report_t oldest_report;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            idle_on        = 1'b1;

    bounded_deque_with_sort_reverse uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .value_in    (value_in),
        .position    (position),
        .busy        (busy),
        .done        (done),
        .value_out   (value_out),
        .status      (status),
        .fill_count  (fill_count),
        .is_empty    (is_empty),
        .front_value (front_value),
        .back_value  (back_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the mirror and queue the result word it must produce
    function automatic void apply_command(cmd_t c, word_t v, pos_t p);
        deque_report_t r;
        data_t         vals [DEPTH];
        data_t         t;
        int            i;
        int            j;
        r.value  = '0;
        r.status = STAT_OK;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (model_count == DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else if (c == CMD_PUSH_FRONT)
                begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    model_ring[model_head] = data_t'(v);
                    model_count++;
                end
                else
                begin
                    model_ring[(model_head + model_count) % DEPTH] = data_t'(v);
                    model_count++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (model_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.value    = word_t'(model_ring[model_head]);
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            CMD_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.value = word_t'(model_ring[(model_head + model_count - 1) % DEPTH]);
                    model_count--;
                end
            end
            CMD_READ:
            begin
                if (model_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else if (int'(p) >= model_count)
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    r.value = word_t'(model_ring[(model_head + int'(p)) % DEPTH]);
                end
            end
            CMD_SORT, CMD_REVERSE:
            begin
                // Work on the values in front-to-back order, then put them back
                for (i = 0; i < model_count; i++)
                begin
                    vals[i] = model_ring[(model_head + i) % DEPTH];
                end
                if (c == CMD_SORT)
                begin
                    for (i = 0; i < model_count; i++)
                    begin
                        for (j = 0; j + 1 < model_count - i; j++)
                        begin
                            if (vals[j + 1] < vals[j])
                            begin
                                t           = vals[j];
                                vals[j]     = vals[j + 1];
                                vals[j + 1] = t;
                            end
                        end
                    end
                end
                else
                begin
                    for (i = 0; i < model_count / 2; i++)
                    begin
                        t                         = vals[i];
                        vals[i]                   = vals[model_count - 1 - i];
                        vals[model_count - 1 - i] = t;
                    end
                end
                for (i = 0; i < model_count; i++)
                begin
                    model_ring[(model_head + i) % DEPTH] = vals[i];
                end
            end
            default:
            begin
                model_count = 0;
                model_head  = 0;
            end
        endcase
        r.fill  = cnt_t'(model_count);
        r.empty = (model_count == 0);
        r.front = (model_count != 0) ? word_t'(model_ring[model_head]) : '0;
        r.back  = (model_count != 0) ?
                  word_t'(model_ring[(model_head + model_count - 1) % DEPTH]) : '0;
        // Append at the tail of the expectation queue
        expected_reports = {expected_reports, r};
    endfunction

    // Send one command word; hold start high when the next word follows at once
    task automatic issue_word(cmd_t c, word_t v, pos_t p);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= c;
        value_in <= v;
        position <= p;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        apply_command(c, v, p);
    endtask

    // Drop start and wait until every result word has come back
    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_reports.size() != 0);
    endtask

    function automatic word_t pick_value();
        int k;
        case ($urandom_range(0, 3))
            0:
            begin
                k = $urandom_range(0, 16);
                return word_t'(k - 8);
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return -32'sd1;
                    default: return '0;
                endcase
            end
            default: return word_t'($urandom());
        endcase
    endfunction

    // Favor positions inside the list, but still reach past the end
    function automatic pos_t pick_position();
        if (model_count > 0 && $urandom_range(0, 3) != 0)
        begin
            return pos_t'($urandom_range(0, model_count - 1));
        end
        return pos_t'($urandom_range(0, 15));
    endfunction

    function automatic cmd_t pick_command(traffic_mode_t mode);
        int unsigned r;
        int unsigned push_cut;
        int unsigned pop_cut;
        int unsigned read_cut;
        int unsigned sort_cut;
        int unsigned rev_cut;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_UP:
            begin
                push_cut = 70; pop_cut = 80; read_cut = 92; sort_cut = 95; rev_cut = 99;
            end
            DRAIN_DOWN:
            begin
                push_cut = 25; pop_cut = 70; read_cut = 88; sort_cut = 93; rev_cut = 98;
            end
            default:
            begin
                push_cut = 40; pop_cut = 65; read_cut = 84; sort_cut = 91; rev_cut = 98;
            end
        endcase
        if (r < push_cut)
        begin
            return r[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end
        if (r < pop_cut)
        begin
            return r[0] ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        if (r < read_cut)
        begin
            return CMD_READ;
        end
        if (r < sort_cut)
        begin
            return CMD_SORT;
        end
        if (r < rev_cut)
        begin
            return CMD_REVERSE;
        end
        return CMD_CLEAR;
    endfunction

    // Pops, read, sort, reverse and clear on an empty list
    task automatic test_empty_list();
        issue_word(CMD_POP_FRONT, '0, '0);
        issue_word(CMD_POP_BACK, '0, '0);
        issue_word(CMD_READ, '0, '0);
        issue_word(CMD_SORT, '0, '0);
        issue_word(CMD_REVERSE, '0, '0);
        issue_word(CMD_CLEAR, '0, '0);
    endtask

    // Extreme values at both ends, reads in and out of range
    task automatic test_edge_values();
        issue_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF, '0);
        issue_word(CMD_PUSH_FRONT, 32'sh8000_0000, '0);
        issue_word(CMD_PUSH_BACK, -32'sd1, '0);
        issue_word(CMD_PUSH_FRONT, '0, '0);
        issue_word(CMD_READ, '0, 4'd0);
        issue_word(CMD_READ, '0, 4'd3);
        issue_word(CMD_READ, '0, 4'd4);
        issue_word(CMD_READ, '0, 4'd15);
        issue_word(CMD_SORT, '0, '0);
        issue_word(CMD_REVERSE, '0, '0);
        issue_word(CMD_POP_FRONT, '0, '0);
        issue_word(CMD_POP_BACK, '0, '0);
        issue_word(CMD_CLEAR, '0, '0);
    endtask

    // Sort and reverse of a single value
    task automatic test_single_value();
        issue_word(CMD_PUSH_BACK, 32'sh5A5A_A5A5, '0);
        issue_word(CMD_SORT, '0, '0);
        issue_word(CMD_REVERSE, '0, '0);
        issue_word(CMD_CLEAR, '0, '0);
    endtask

    // Fill the store, push past full, then read both ends, sort and reverse
    task automatic test_full_store();
        while (model_count < DEPTH)
        begin
            issue_word($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                       pick_value(), '0);
        end
        issue_word(CMD_PUSH_FRONT, pick_value(), '0);
        issue_word(CMD_PUSH_BACK, pick_value(), '0);
        issue_word(CMD_READ, '0, 4'd15);
        issue_word(CMD_SORT, '0, '0);
        issue_word(CMD_READ, '0, 4'd0);
        issue_word(CMD_REVERSE, '0, '0);
        issue_word(CMD_POP_FRONT, '0, '0);
        issue_word(CMD_POP_BACK, '0, '0);
        issue_word(CMD_CLEAR, '0, '0);
    endtask

    // Random traffic in blocks that fill, drain or mix, with and without idling
    task automatic test_random_traffic(int unsigned n_words);
        traffic_mode_t mode;
        mode = MIXED;
        for (int unsigned k = 0; k < n_words; k++)
        begin
            if (k % 32 == 0)
            begin
                mode    = traffic_mode_t'($urandom_range(0, 2));
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (k % 100 == 99)
            begin
                drain_results();
            end
            issue_word(pick_command(mode), pick_value(), pick_position());
        end
    endtask

    // Compare one field of a result word
    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Check every result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual value %h",
                         $time, value_out);
                mismatch_count++;
            end
            else
            begin
                // Take the head of the expectation queue
                oldest_report = expected_reports[0];
                expected_reports.delete(0);
                check_field("value_out", oldest_report.value, value_out);
                check_field("status", 32'(oldest_report.status), 32'(status));
                check_field("fill_count", 32'(oldest_report.fill), 32'(fill_count));
                check_field("is_empty", 32'(oldest_report.empty), 32'(is_empty));
                check_field("front_value", oldest_report.front, front_value);
                check_field("back_value", oldest_report.back, back_value);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            model_ring[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edge_values();
        drain_results();
        test_single_value();
        idle_on = 1'b0;
        test_full_store();
        drain_results();
        idle_on = 1'b1;
        test_random_traffic(400);

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/dq_pkg.sv
design/dq_ring.sv
design/dq_cmp.sv
design/bounded_deque_with_sort_reverse.sv
design/dq_checker.sv
sim/bounded_deque_with_sort_reverse_tb.sv
